>>> hdl/urpd_pkg.sv
// ----------------------------------------------------------------------------
// urpd_pkg: shared types and constants of the ultrasonic presence detector
// Phase codes, register indexes, field widths and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package urpd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 2'd2;

    localparam int THRESH_W = 10;
    localparam int PERIOD_W = 20;
    localparam int PHCNT_W  = 16;
    localparam int DIST_W   = 10;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd30;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd100000;

    // trigger pulse shape in ticks
    localparam logic [PHCNT_W-1:0] TRIG_LOW_TICKS  = 16'd2;
    localparam logic [PHCNT_W-1:0] TRIG_HIGH_TICKS = 16'd10;
    localparam logic [DIST_W-1:0]  DIST_MAX        = 10'd1023;

    // measurement phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TLOW  = 3'd1;
    localparam logic [2:0] PH_THIGH = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_MEAS  = 3'd4;

    // one result word
    typedef struct packed {
        logic trigger_level;
        logic report_valid;
        logic report_present;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/urpd_in_if.sv
// ----------------------------------------------------------------------------
// urpd_in_if: tick channel into the detector
// Valid/ready channel carrying the sampled echo level of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface urpd_in_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink   (input valid, input echo_level, output ready);
endinterface

`default_nettype wire

>>> hdl/urpd_out_if.sv
// ----------------------------------------------------------------------------
// urpd_out_if: result channel out of the detector
// Valid/ready channel carrying trigger level and presence report per tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface urpd_out_if;
    logic valid;
    logic ready;
    logic trigger_level;
    logic report_valid;
    logic report_present;

    modport source (output valid, output trigger_level, output report_valid,
                    output report_present, input ready);
    modport sink   (input valid, input trigger_level, input report_valid,
                    input report_present, output ready);
endinterface

`default_nettype wire

>>> hdl/ultrasonic_range_presence_detector_unit.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_presence_detector_unit: echo-ranging presence detector
//
// s_in carries one word per 1 us tick: the sampled echo pin level. For every
// accepted tick exactly one word leaves on m_out: the trigger pin level for
// that tick plus an optional presence report (report_valid/report_present).
// Registers (i_cfg_we/i_cfg_idx/i_cfg_data): 0 enable, 1 threshold_cm,
// 2 period_us; write them while no tick is in flight.
// Result path: the word of an accepted tick is registered in the output buffer and leaves on m_out from there.
// Throughput: one tick per cycle while s_in.ready is high; the sequencer update for a tick is a single
// pass of logic between the state registers and the result register.
// Stall: results queue in a two-word output buffer; s_in.ready drops only
// when both words are held, and returns once m_out drains.
// Reset: enable 0, threshold 30 cm, period 100000 us, sequencer idle, output
// buffer empty. While disabled each tick yields trigger 0 and no report.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_presence_detector_unit
    import urpd_pkg::*;
#(
    parameter int ECHO_WAIT_LIMIT_US  = 30000,
    parameter int ECHO_WIDTH_LIMIT_US = 38000,
    parameter int US_PER_CM           = 58
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    urpd_in_if.sink                    s_in,
    urpd_out_if.source                 m_out
);

    t_result w_result;
    t_result w_out;
    logic    w_accept;

    assign w_accept = s_in.valid && s_in.ready;

    urpd_core #(
        .ECHO_WAIT_LIMIT_US  (ECHO_WAIT_LIMIT_US),
        .ECHO_WIDTH_LIMIT_US (ECHO_WIDTH_LIMIT_US),
        .US_PER_CM           (US_PER_CM)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_echo_level (s_in.echo_level),
        .o_result     (w_result)
    );

    urpd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_in.valid),
        .i_data  (w_result),
        .o_ready (s_in.ready),
        .o_valid (m_out.valid),
        .o_data  (w_out),
        .i_ready (m_out.ready)
    );

    assign m_out.trigger_level  = w_out.trigger_level;
    assign m_out.report_valid   = w_out.report_valid;
    assign m_out.report_present = w_out.report_present;

    // a full buffer always has a word on the output
    a_full_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_in.ready |-> m_out.valid)
        else $error("input stalled with empty output register");

    // present is only ever reported inside a report
    a_present_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_out.valid && m_out.report_present |-> m_out.report_valid)
        else $error("report_present without report_valid");

    // after a disable write the sequencer is quiet
    a_disable_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == REG_ENABLE && !i_cfg_data[0]
        |=> !w_result.trigger_level && !w_result.report_valid)
        else $error("activity after disable");

    // no trigger or report out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !w_result.trigger_level && !w_result.report_valid)
        else $error("activity right after reset");

endmodule

`default_nettype wire

>>> hdl/urpd_core.sv
// ----------------------------------------------------------------------------
// urpd_core: configuration registers, run sequencer and ranging counters
// Computes one result per accepted tick from the state registers and the
// echo sample, and updates the state on acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

module urpd_core
    import urpd_pkg::*;
#(
    parameter int ECHO_WAIT_LIMIT_US  = 30000,
    parameter int ECHO_WIDTH_LIMIT_US = 38000,
    parameter int US_PER_CM           = 58
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic                  i_echo_level,
    output t_result                    o_result
);

    localparam int PRE_W = $clog2(US_PER_CM + 1);
    localparam logic [PRE_W-1:0]   CM_DIV    = PRE_W'(US_PER_CM);
    localparam logic [PHCNT_W-1:0] WAIT_LIM  = PHCNT_W'(ECHO_WAIT_LIMIT_US);
    localparam logic [PHCNT_W-1:0] WIDTH_LIM = PHCNT_W'(ECHO_WIDTH_LIMIT_US);

    // configuration registers
    logic                r_enable;
    logic [THRESH_W-1:0] r_threshold;
    logic [PERIOD_W-1:0] r_period;

    // run state
    logic [2:0]          r_phase,        n_phase;
    logic [PHCNT_W-1:0]  r_phase_count,  n_phase_count;
    logic [PERIOD_W-1:0] r_period_count, n_period_count;
    logic                r_run_pending,  n_run_pending;
    logic [PRE_W-1:0]    r_cm_prescale,  n_cm_prescale;
    logic [DIST_W-1:0]   r_distance,     n_distance;
    logic                r_last_present, n_last_present;
    t_result             n_result;

    // one tick of the sequencer
    always_comb begin
        logic [PERIOD_W:0] nxt;
        logic              do_count;
        logic [PRE_W-1:0]  pre_inc;
        logic              det;

        n_phase        = r_phase;
        n_phase_count  = r_phase_count;
        n_period_count = r_period_count;
        n_run_pending  = r_run_pending;
        n_cm_prescale  = r_cm_prescale;
        n_distance     = r_distance;
        n_last_present = r_last_present;
        n_result       = '0;
        do_count       = 1'b0;
        pre_inc        = '0;
        det            = 1'b0;
        nxt            = {1'b0, r_period_count} + 1'b1;

        if (r_enable) begin
            // period timer
            n_period_count = (nxt >= {1'b0, r_period}) ? '0 : nxt[PERIOD_W-1:0];
            if (r_period_count == '0) begin
                if (r_phase == PH_IDLE) begin
                    n_phase       = PH_TLOW;
                    n_phase_count = '0;
                end else begin
                    n_run_pending = 1'b1;
                end
            end

            case (n_phase)
                PH_TLOW: begin
                    n_phase_count = n_phase_count + 1'b1;
                    if (n_phase_count >= TRIG_LOW_TICKS) begin
                        n_phase       = PH_THIGH;
                        n_phase_count = '0;
                    end
                end
                PH_THIGH: begin
                    n_result.trigger_level = 1'b1;
                    n_phase_count = n_phase_count + 1'b1;
                    if (n_phase_count >= TRIG_HIGH_TICKS) begin
                        n_phase       = PH_WAIT;
                        n_phase_count = '0;
                    end
                end
                PH_WAIT: begin
                    if (i_echo_level) begin
                        n_phase       = PH_MEAS;
                        n_phase_count = '0;
                        n_cm_prescale = '0;
                        n_distance    = '0;
                        do_count      = 1'b1;
                    end else begin
                        n_phase_count = n_phase_count + 1'b1;
                        // echo timeout
                        if (n_phase_count >= WAIT_LIM) begin
                            n_result.report_valid = r_last_present;
                            n_last_present = 1'b0;
                            n_phase        = n_run_pending ? PH_TLOW : PH_IDLE;
                            n_run_pending  = 1'b0;
                            n_phase_count  = '0;
                        end
                    end
                end
                PH_MEAS: begin
                    do_count = i_echo_level;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            // high tick: width counter and cm prescaler
            if (do_count) begin
                n_phase_count = n_phase_count + 1'b1;
                pre_inc       = n_cm_prescale + 1'b1;
                if (pre_inc >= CM_DIV) begin
                    n_cm_prescale = '0;
                    if (n_distance < DIST_MAX) begin
                        n_distance = n_distance + 1'b1;
                    end
                end else begin
                    n_cm_prescale = pre_inc;
                end
            end

            // end of echo or width cap: classify the run
            if (n_phase == PH_MEAS && (!i_echo_level || n_phase_count >= WIDTH_LIM)) begin
                det = (n_distance != '0) && (n_distance <= r_threshold);
                n_result.report_valid   = det | n_last_present;
                n_result.report_present = det;
                n_last_present = det;
                n_cm_prescale  = '0;
                n_distance     = '0;
                n_phase        = n_run_pending ? PH_TLOW : PH_IDLE;
                n_run_pending  = 1'b0;
                n_phase_count  = '0;
            end
        end
    end

    assign o_result = n_result;

    // configuration writes and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable       <= 1'b0;
            r_threshold    <= THRESH_RESET;
            r_period       <= PERIOD_RESET;
            r_phase        <= PH_IDLE;
            r_phase_count  <= '0;
            r_period_count <= '0;
            r_run_pending  <= 1'b0;
            r_cm_prescale  <= '0;
            r_distance     <= '0;
            r_last_present <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE: begin
                    r_enable <= i_cfg_data[0];
                    if (!i_cfg_data[0]) begin
                        r_phase        <= PH_IDLE;
                        r_phase_count  <= '0;
                        r_period_count <= '0;
                        r_run_pending  <= 1'b0;
                        r_cm_prescale  <= '0;
                        r_distance     <= '0;
                        r_last_present <= 1'b0;
                    end else if (!r_enable) begin
                        r_period_count <= '0;
                    end
                end
                REG_THRESHOLD: r_threshold <= i_cfg_data[THRESH_W-1:0];
                REG_PERIOD:    r_period    <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_phase_count  <= n_phase_count;
            r_period_count <= n_period_count;
            r_run_pending  <= n_run_pending;
            r_cm_prescale  <= n_cm_prescale;
            r_distance     <= n_distance;
            r_last_present <= n_last_present;
        end
    end

endmodule

`default_nettype wire

>>> hdl/urpd_out_reg.sv
// ----------------------------------------------------------------------------
// urpd_out_reg: result register with skid stage
// Two-entry output buffer; ready toward the core stays high until both
// entries hold a word, so a stalled receiver never drops a result.
// ----------------------------------------------------------------------------
`default_nettype none

module urpd_out_reg
    import urpd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_data,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_data,
    input  wire logic    i_ready
);

    logic    r_main_v;
    logic    r_skid_v;
    t_result r_main;
    t_result r_skid;
    logic    push;
    logic    pop;

    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;
    assign push    = i_valid && !r_skid_v;
    assign pop     = r_main_v && i_ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || pop) begin
            r_main_v <= r_skid_v || push;
            r_skid_v <= 1'b0;
        end else if (push) begin
            r_skid_v <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (!r_main_v || pop) begin
            if (r_skid_v) begin
                r_main <= r_skid;
            end else if (push) begin
                r_main <= i_data;
            end
        end else if (push) begin
            r_skid <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> verif/ultrasonic_range_presence_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// ultrasonic_range_presence_detector_unit_tb: presence detector testbench
// Feeds echo ticks through s_in and predicts each m_out word (trigger level
// plus presence report). Covers trigger shaping, echo timeout, the width cap,
// threshold edges, period restarts, disable mid-run, and random echo pulses
// under random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_presence_detector_unit_tb;
    import urpd_pkg::*;

    localparam int WAIT_LIMIT  = 30000;
    localparam int WIDTH_LIMIT = 38000;
    localparam int US_PER_CM   = 58;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int HOLD_CYCLES = 48;
    localparam int STALL_LIMIT = 3000;
    localparam int PRINT_LIMIT = 40;

    // ------------------------------------------------------------------
    // echo-ranging predictor and queue of words still due
    // ------------------------------------------------------------------
    class echo_ranging_model;
        logic                enable;
        logic [THRESH_W-1:0] threshold;
        logic [PERIOD_W-1:0] period_len;
        logic [2:0]          phase;
        logic [PHCNT_W-1:0]  phase_count;
        logic [PERIOD_W-1:0] period_count;
        logic                run_pending;
        logic [5:0]          cm_prescale;
        logic [DIST_W-1:0]   distance;
        logic                last_present;
        t_result             due_words[$];
        int                  words_checked;

        function new();
            enable        = 1'b0;
            threshold     = THRESH_RESET;
            period_len    = PERIOD_RESET;
            words_checked = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase        = PH_IDLE;
            phase_count  = '0;
            period_count = '0;
            run_pending  = 1'b0;
            cm_prescale  = '0;
            distance     = '0;
            last_present = 1'b0;
        endfunction

        // one echo-high tick: width and centimetre counters
        function void count_high();
            phase_count++;
            cm_prescale++;
            if (cm_prescale >= US_PER_CM) begin
                cm_prescale = '0;
                if (distance < DIST_MAX) distance++;
            end
        endfunction

        function void end_run();
            phase       = PH_IDLE;
            phase_count = '0;
            if (run_pending) begin
                run_pending = 1'b0;
                phase       = PH_TLOW;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ENABLE: begin
                    if (!data[0]) clear_state();
                    else if (!enable) period_count = '0;
                    enable = data[0];
                end
                REG_THRESHOLD: threshold = data[THRESH_W-1:0];
                REG_PERIOD:    period_len = data[PERIOD_W-1:0];
                default: ;
            endcase
        endfunction

        // advance by one accepted tick and queue the word it produces
        function void take_tick(logic echo);
            t_result r;
            logic    start;
            logic    near;
            int      next_cnt;
            r = '0;
            if (enable) begin
                start    = (period_count == 0);
                next_cnt = period_count + 1;
                period_count = (next_cnt >= period_len) ? '0 : next_cnt[PERIOD_W-1:0];
                if (start) begin
                    if (phase == PH_IDLE) begin
                        phase       = PH_TLOW;
                        phase_count = '0;
                    end else begin
                        run_pending = 1'b1;
                    end
                end

                case (phase)
                    PH_TLOW: begin
                        phase_count++;
                        if (phase_count >= TRIG_LOW_TICKS) begin
                            phase       = PH_THIGH;
                            phase_count = '0;
                        end
                    end
                    PH_THIGH: begin
                        r.trigger_level = 1'b1;
                        phase_count++;
                        if (phase_count >= TRIG_HIGH_TICKS) begin
                            phase       = PH_WAIT;
                            phase_count = '0;
                        end
                    end
                    PH_WAIT: begin
                        if (echo) begin
                            phase       = PH_MEAS;
                            phase_count = '0;
                            cm_prescale = '0;
                            distance    = '0;
                            count_high();
                        end else begin
                            phase_count++;
                            // echo never came: gone only if last run saw it
                            if (phase_count >= WAIT_LIMIT) begin
                                r.report_valid = last_present;
                                last_present   = 1'b0;
                                end_run();
                            end
                        end
                    end
                    PH_MEAS: begin
                        if (echo) count_high();
                    end
                    default: phase = PH_IDLE;
                endcase

                // falling edge or width cap closes the measurement
                if (phase == PH_MEAS && (!echo || phase_count >= WIDTH_LIMIT)) begin
                    near = (distance != 0) && (distance <= threshold);
                    if (near) begin
                        r.report_valid   = 1'b1;
                        r.report_present = 1'b1;
                        last_present     = 1'b1;
                    end else begin
                        if (last_present) r.report_valid = 1'b1;
                        last_present = 1'b0;
                    end
                    cm_prescale = '0;
                    distance    = '0;
                    end_run();
                end
            end
            due_words.push_back(r);
        endfunction

        // compare against the oldest due word; empty string when it matches
        function string match_word(t_result got);
            t_result want;
            string   msg;
            if (due_words.size() == 0)
                return $sformatf("word with no tick outstanding: %b", got);
            want = due_words.pop_front();
            msg  = "";
            if (got.trigger_level !== want.trigger_level)
                msg = {msg, $sformatf(" trigger %b/%b", got.trigger_level, want.trigger_level)};
            if (got.report_valid !== want.report_valid)
                msg = {msg, $sformatf(" report_valid %b/%b", got.report_valid,
                                      want.report_valid)};
            if (got.report_present !== want.report_present)
                msg = {msg, $sformatf(" report_present %b/%b", got.report_present,
                                      want.report_present)};
            if (msg != "") msg = $sformatf("word %0d (got/want):%s", words_checked, msg);
            words_checked++;
            return msg;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // signals and block
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    urpd_in_if  in_ch ();
    urpd_out_if out_ch ();

    echo_ranging_model model;

    int mismatch_count = 0;
    int reports_seen   = 0;
    int ticks_sent     = 0;
    int idle_pct       = 34;
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int stall_cycles   = 0;

    ultrasonic_range_presence_detector_unit #(
        .ECHO_WAIT_LIMIT_US  (WAIT_LIMIT),
        .ECHO_WIDTH_LIMIT_US (WIDTH_LIMIT),
        .US_PER_CM           (US_PER_CM)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch.sink),
        .m_out      (out_ch.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic flag_mismatch(string msg);
        if (mismatch_count < PRINT_LIMIT) $display("MISMATCH %s", msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // result side: check each accepted word, then drive ready
    // ------------------------------------------------------------------
    initial out_ch.ready = 1'b0;

    always @(posedge i_clk) begin : result_side
        t_result got;
        string   msg;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.trigger_level, out_ch.report_valid, out_ch.report_present};
            msg = model.match_word(got);
            if (msg != "") flag_mismatch(msg);
            if (out_ch.report_valid) reports_seen++;
        end
        // long back-off on request, random stalls otherwise
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog: ends the run when nothing moves for too long
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // drive tasks
    // ------------------------------------------------------------------
    task automatic send_tick(logic echo);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.echo_level <= echo;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        model.take_tick(echo);
        ticks_sent++;
    endtask

    // stop offering and wait for every due word
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (model.due_words.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        model.write_reg(idx, data);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // noise until the echo wait opens, then gap lows, width highs, falling edge
    task automatic run_pulse(int gap, int width);
        while (model.phase != PH_WAIT) send_tick($urandom_range(1) != 0);
        repeat (gap) if (model.phase == PH_WAIT) send_tick(1'b0);
        repeat (width) if (model.phase inside {PH_WAIT, PH_MEAS}) send_tick(1'b1);
        if (model.phase == PH_MEAS) send_tick(1'b0);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int phase_no;
        int thr;
        int per;
        int quota;
        int pick;
        int dist_cm;
        int width;
        int gap;
        int base_ticks;
        int base_reports;

        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = REG_ENABLE;
        i_cfg_data       = '0;
        in_ch.valid      = 1'b0;
        in_ch.echo_level = 1'b0;
        model            = new();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled: trigger low, no report
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // upper data bits dropped, spare index ignored, enable twice
        write_reg(REG_THRESHOLD, 20'hFFC05);
        write_reg(REG_SPARE, 20'hFFFFF);
        write_reg(REG_PERIOD, 20'd1);
        write_reg(REG_ENABLE, 20'd1);
        write_reg(REG_ENABLE, 20'hFFFFF);

        // present, gone, silent absent, threshold edge, gone again
        run_pulse(0, 3 * US_PER_CM);
        run_pulse(4, US_PER_CM - 1);
        run_pulse(2, 10);
        run_pulse(1, 5 * US_PER_CM + US_PER_CM - 1);
        run_pulse(0, 6 * US_PER_CM);

        // echo timeout after a present run reports gone
        run_pulse(3, 2 * US_PER_CM);
        run_pulse(WAIT_LIMIT, 0);

        // width cap with the widest threshold, then timeouts loud and silent
        drain();
        write_reg(REG_THRESHOLD, 20'd1023);
        run_pulse(0, WIDTH_LIMIT);
        run_pulse(WAIT_LIMIT, 0);
        run_pulse(WAIT_LIMIT, 0);

        // zero threshold: 1 cm is still out of range
        drain();
        write_reg(REG_THRESHOLD, 20'd0);
        run_pulse(0, US_PER_CM);

        // disable mid-measurement clears the present mark
        drain();
        write_reg(REG_THRESHOLD, 20'd5);
        run_pulse(0, 2 * US_PER_CM);
        while (model.phase != PH_WAIT) send_tick(1'b0);
        repeat (3) send_tick(1'b1);
        drain();
        write_reg(REG_ENABLE, 20'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain();
        write_reg(REG_ENABLE, 20'd1);
        run_pulse(0, 10);

        // random settings, mostly well-formed echoes with random content
        base_ticks   = ticks_sent;
        base_reports = reports_seen;
        for (phase_no = 0;
             phase_no < 80 && (ticks_sent - base_ticks < 1350 ||
                               reports_seen - base_reports < 48);
             phase_no++) begin
            drain();
            case (phase_no)
                0: begin thr = 0;    per = 0;        end
                1: begin thr = 1023; per = 20'hFFFFF; end
                2: begin thr = 1;    per = 1;        end
                3: begin thr = 3;    per = 1000;     end
                default: begin
                    thr = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(1, 8);
                    case ($urandom_range(3))
                        0:       per = $urandom_range(1);
                        1:       per = $urandom_range(2, 40);
                        2:       per = $urandom_range(100, 400);
                        default: per = 1000;
                    endcase
                end
            endcase
            write_reg(REG_ENABLE, 20'd0);
            write_reg(REG_THRESHOLD, thr[CFG_DATA_W-1:0]);
            write_reg(REG_PERIOD, per[CFG_DATA_W-1:0]);
            write_reg(REG_ENABLE, 20'd1);

            // one phase runs without random idling on either side (the receiver back-off still applies)
            idle_pct = (phase_no == 2) ? 0 : 34;
            // receiver backs off while ticks keep coming
            if (phase_no % 7 == 2) hold_asks++;

            quota = ticks_sent + $urandom_range(150, 400);
            while (ticks_sent < quota) begin
                if ($urandom_range(49) == 0) drain();
                pick = $urandom_range(99);
                if (model.phase == PH_IDLE && !model.run_pending && model.period_count != 0 &&
                    int'(model.period_len) - int'(model.period_count) > 2000) begin
                    // next run is far off: noise only
                    repeat ($urandom_range(5, 30)) send_tick($urandom_range(1) != 0);
                end else if (pick < 75) begin
                    if (thr > 20) dist_cm = $urandom_range(1, 20);
                    else dist_cm = thr - 1 + int'($urandom_range(2));
                    if (dist_cm < 0) dist_cm = 0;
                    width = dist_cm * US_PER_CM + int'($urandom_range(US_PER_CM - 1));
                    if (width == 0) width = 1;
                    gap = ($urandom_range(99) < 80) ? $urandom_range(20) : $urandom_range(21, 400);
                    run_pulse(gap, width);
                end else if (pick < 90) begin
                    // glitch: too short for a centimetre
                    run_pulse($urandom_range(30), $urandom_range(1, US_PER_CM - 1));
                end else begin
                    repeat ($urandom_range(5, 30)) send_tick($urandom_range(1) != 0);
                end
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && model.due_words.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/urpd_pkg.sv
hdl/urpd_in_if.sv
hdl/urpd_out_if.sv
hdl/urpd_core.sv
hdl/urpd_out_reg.sv
hdl/ultrasonic_range_presence_detector_unit.sv
verif/ultrasonic_range_presence_detector_unit_tb.sv
